@@ design/radio_frame_assembler_unit_macros.svh @@
// Assertion macros shared by the frame assembler modules.
// No dependencies; include with the bare file name.
`ifndef RADIO_FRAME_ASSEMBLER_UNIT_MACROS_SVH
`define RADIO_FRAME_ASSEMBLER_UNIT_MACROS_SVH

// Condition must hold at every clock edge outside reset
`define RFA_ASSERT_HOLDS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle, outside reset
`define RFA_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ design/rfa_pkg.sv @@
// Shared types and constants of the radio frame assembler.
// No dependencies; imported by every module of the block.
package rfa_pkg;

   // Longest payload a start transaction may request
   localparam logic [15:0] MaxPayload  = 16'd128;
   localparam logic [31:0] BroadcastId = 32'hFFFF_FFFF;
   localparam logic [7:0]  HopReset    = 8'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_SOURCE_ID  = 2'd0;
   localparam logic [1:0] CSR_HOP_LIMIT  = 2'd1;
   localparam logic [1:0] CSR_LINK_READY = 2'd2;

   // Result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_TOO_LONG  = 2'd1;
   localparam logic [1:0] ST_STRAY     = 2'd2;
   localparam logic [1:0] ST_NO_LINK   = 2'd3;

   // Input item kinds
   localparam logic KIND_START   = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   // Command operations passed from front to back
   localparam logic [1:0] OP_HEADER  = 2'd0;
   localparam logic [1:0] OP_PAYLOAD = 2'd1;
   localparam logic [1:0] OP_STATUS  = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  data;     // type byte of a header, or the payload byte
      logic [31:0] dest;     // resolved destination
      logic [7:0]  len;      // payload length
      logic [7:0]  seq;      // sequence number of a header
      logic [1:0]  status;
      logic        last;     // checksum follows this command
   } cmd_type;

endpackage

@@ design/rfa_front.sv @@
// Front end: accepts request transactions, classifies them and tracks the open frame.
// Depends on rfa_pkg.
module rfa_front import rfa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic        link_ready,
   input  logic        kind,
   input  logic [7:0]  frame_type,
   input  logic        dest_given,
   input  logic [31:0] dest_node,
   input  logic [15:0] body_length,
   input  logic [7:0]  body_byte,
   output cmd_type     cmd
);

   logic       frame_open_ff, frame_open_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [7:0] seq_ff, seq_in;

   // Classify the transaction and work out the next frame state
   always_comb begin
      frame_open_in = frame_open_ff;
      bytes_left_in = bytes_left_ff;
      seq_in        = seq_ff;
      cmd.op        = OP_STATUS;
      cmd.data      = frame_type;
      cmd.dest      = dest_given ? dest_node : BroadcastId;
      cmd.len       = body_length[7:0];
      cmd.seq       = seq_ff;
      cmd.status    = ST_OK;
      cmd.last      = 1'b0;
      if (kind == KIND_START) begin
         if (!link_ready) begin
            cmd.status = ST_NO_LINK;
         end else if (body_length > MaxPayload) begin
            cmd.status = ST_TOO_LONG;
         end else begin
            cmd.op        = OP_HEADER;
            cmd.last      = (body_length == 16'd0);
            seq_in        = seq_ff + 8'd1;
            frame_open_in = (body_length != 16'd0);
            bytes_left_in = body_length[7:0];
         end
      end else begin
         cmd.data = body_byte;
         if (!frame_open_ff) begin
            cmd.status = ST_STRAY;
         end else begin
            cmd.op        = OP_PAYLOAD;
            cmd.last      = (bytes_left_ff == 8'd1);
            bytes_left_in = bytes_left_ff - 8'd1;
            frame_open_in = (bytes_left_ff != 8'd1);
         end
      end
   end

   // Advance frame state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         bytes_left_ff <= 8'd0;
         seq_ff        <= 8'd0;
      end else if (accept) begin
         frame_open_ff <= frame_open_in;
         bytes_left_ff <= bytes_left_in;
         seq_ff        <= seq_in;
      end
   end

endmodule

@@ design/rfa_queue.sv @@
// Short command queue between the front and back ends.
// Depends on rfa_pkg and the assertion macro header.
`include "radio_frame_assembler_unit_macros.svh"
module rfa_queue import rfa_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output cmd_type head_cmd
);

   localparam int PtrW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   cmd_type         slot_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full      = (count_ff == CntW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed commands
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `RFA_ASSERT_HOLDS(a_count_bound, clock, reset, count_ff <= CntW'(DEPTH), "queue overfilled")
   `RFA_ASSERT_IMPLIES(a_no_push_full, clock, reset, full, !push, "push into full queue")
   `RFA_ASSERT_IMPLIES(a_no_pop_empty, clock, reset, !not_empty, !pop, "pop from empty queue")

endmodule

@@ design/rfa_back.sv @@
// Back end: serialises queued commands into frame bytes and keeps the checksum.
// Depends on rfa_pkg and the assertion macro header.
`include "radio_frame_assembler_unit_macros.svh"
module rfa_back import rfa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        have_cmd,
   input  cmd_type     cmd,
   input  logic [31:0] source_id,
   input  logic [7:0]  hop_limit,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_frame_end,
   output logic [1:0]  rsp_status
);

   // Byte positions within a frame
   localparam logic [3:0] STEP_TYPE   = 4'd0;
   localparam logic [3:0] STEP_SRC0   = 4'd1;
   localparam logic [3:0] STEP_SRC1   = 4'd2;
   localparam logic [3:0] STEP_SRC2   = 4'd3;
   localparam logic [3:0] STEP_SRC3   = 4'd4;
   localparam logic [3:0] STEP_DST0   = 4'd5;
   localparam logic [3:0] STEP_DST1   = 4'd6;
   localparam logic [3:0] STEP_DST2   = 4'd7;
   localparam logic [3:0] STEP_DST3   = 4'd8;
   localparam logic [3:0] STEP_SEQ    = 4'd9;
   localparam logic [3:0] STEP_HOP    = 4'd10;
   localparam logic [3:0] STEP_LEN_LO = 4'd11;
   localparam logic [3:0] STEP_LEN_HI = 4'd12;
   localparam logic [3:0] STEP_SUM_LO = 4'd13;
   localparam logic [3:0] STEP_SUM_HI = 4'd14;

   logic [3:0]  step_ff, step_in;
   logic [15:0] sum_ff, sum_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        frame_end_ff, frame_end_in;
   logic [1:0]  status_ff, status_in;
   logic        out_ready;
   logic        fire;
   logic        done;
   logic [7:0]  byte_sel;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign fire      = have_cmd && out_ready;
   assign pop       = fire && done;

   // Select the byte for the current position
   always_comb begin
      unique case (step_ff)
         STEP_TYPE:   byte_sel = (cmd.op == OP_STATUS) ? 8'd0 : cmd.data;
         STEP_SRC0:   byte_sel = source_id[7:0];
         STEP_SRC1:   byte_sel = source_id[15:8];
         STEP_SRC2:   byte_sel = source_id[23:16];
         STEP_SRC3:   byte_sel = source_id[31:24];
         STEP_DST0:   byte_sel = cmd.dest[7:0];
         STEP_DST1:   byte_sel = cmd.dest[15:8];
         STEP_DST2:   byte_sel = cmd.dest[23:16];
         STEP_DST3:   byte_sel = cmd.dest[31:24];
         STEP_SEQ:    byte_sel = cmd.seq;
         STEP_HOP:    byte_sel = hop_limit;
         STEP_LEN_LO: byte_sel = cmd.len;
         STEP_LEN_HI: byte_sel = 8'd0;
         STEP_SUM_LO: byte_sel = sum_ff[7:0];
         STEP_SUM_HI: byte_sel = sum_ff[15:8];
         default:     byte_sel = 8'd0;
      endcase
   end

   // Decide the next position and whether the command is finished
   always_comb begin
      step_in = step_ff;
      done    = 1'b0;
      priority if (cmd.op == OP_STATUS || step_ff == STEP_SUM_HI) begin
         done = 1'b1;
      end else if (step_ff == STEP_SUM_LO) begin
         step_in = STEP_SUM_HI;
      end else if (cmd.op == OP_PAYLOAD || step_ff == STEP_LEN_HI) begin
         if (cmd.last) begin
            step_in = STEP_SUM_LO;
         end else begin
            done = 1'b1;
         end
      end else begin
         step_in = step_ff + 4'd1;
      end
      if (done) begin
         step_in = STEP_TYPE;
      end
   end

   // Accumulate the checksum over every emitted header and payload byte
   always_comb begin
      sum_in = sum_ff;
      if (fire && cmd.op != OP_STATUS && step_ff < STEP_SUM_LO) begin
         if (cmd.op == OP_HEADER && step_ff == STEP_TYPE) begin
            sum_in = {8'd0, byte_sel};
         end else begin
            sum_in = sum_ff + {8'd0, byte_sel};
         end
      end
   end

   // Load the output register when it is free or being taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_byte_in  = out_byte_ff;
      frame_end_in = frame_end_ff;
      status_in    = status_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         out_byte_in  = byte_sel;
         frame_end_in = (cmd.op == OP_STATUS) || (step_ff == STEP_SUM_HI);
         status_in    = cmd.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_TYPE;
         sum_ff       <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            step_ff <= step_in;
         end
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff  <= out_byte_in;
      frame_end_ff <= frame_end_in;
      status_ff    <= status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_frame_end = frame_end_ff;
   assign rsp_status    = status_ff;

   `RFA_ASSERT_HOLDS(a_step_bound, clock, reset, step_ff <= STEP_SUM_HI, "frame position out of range")
   `RFA_ASSERT_IMPLIES(a_status_ends, clock, reset, rsp_valid_ff && status_ff != ST_OK, frame_end_ff && out_byte_ff == 8'd0, "status result not terminal")
   `RFA_ASSERT_IMPLIES(a_status_single, clock, reset, have_cmd && cmd.op == OP_STATUS, step_ff == STEP_TYPE, "status command mid-frame")

endmodule

@@ design/radio_frame_assembler_unit.sv @@
// Radio frame assembler. A start transaction yields a 13-byte header (type, source id, destination
// id, sequence, hop limit, 16-bit length, multi-byte fields low byte first) and each payload
// transaction one byte; after the final payload byte, or straight after the header for an empty
// payload, a 16-bit additive checksum follows low byte first. Refused requests give one
// status-only result. Results leave one per cycle through an output register while rsp_stall
// is low; a payload transaction gives one byte, a header 13, and the checksum two more. Request
// transactions are taken one per cycle while the QUEUE_DEPTH-entry command queue has room; the
// serialiser in the back end sets the sustained rate.
// Depends on rfa_pkg, rfa_front, rfa_queue and rfa_back.
module radio_frame_assembler_unit import rfa_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   // Configuration writes
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   // Request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_frame_type,
   input  logic        req_dest_given,
   input  logic [31:0] req_dest_node,
   input  logic [15:0] req_body_length,
   input  logic [7:0]  req_body_byte,
   // Response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_frame_end,
   output logic [1:0]  rsp_status
);

   logic [31:0] source_id_ff;
   logic [7:0]  hop_limit_ff;
   logic        link_ready_ff;
   logic        accept;
   logic        full;
   logic        not_empty;
   logic        pop;
   cmd_type     front_cmd;
   cmd_type     head_cmd;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         source_id_ff  <= 32'd0;
         hop_limit_ff  <= HopReset;
         link_ready_ff <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SOURCE_ID:  source_id_ff  <= csr_wdata;
            CSR_HOP_LIMIT:  hop_limit_ff  <= csr_wdata[7:0];
            CSR_LINK_READY: link_ready_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign req_stall = full;
   assign accept    = req_valid && !full;

   rfa_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .link_ready  (link_ready_ff),
      .kind        (req_kind),
      .frame_type  (req_frame_type),
      .dest_given  (req_dest_given),
      .dest_node   (req_dest_node),
      .body_length (req_body_length),
      .body_byte   (req_body_byte),
      .cmd         (front_cmd)
   );

   rfa_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_cmd  (front_cmd),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head_cmd  (head_cmd)
   );

   rfa_back u_back (
      .clock         (clock),
      .reset         (reset),
      .have_cmd      (not_empty),
      .cmd           (head_cmd),
      .source_id     (source_id_ff),
      .hop_limit     (hop_limit_ff),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_frame_end (rsp_frame_end),
      .rsp_status    (rsp_status)
   );

endmodule
